// ===== hw/rtl/pts_pkg.sv =====
package pts_pkg;

  localparam int TASK_COUNT  = 16;
  localparam int TASK_W      = $clog2(TASK_COUNT);
  localparam int CNT_W       = $clog2(TASK_COUNT + 1);
  localparam int LEVEL_COUNT = 32;
  localparam int LEVEL_W     = $clog2(LEVEL_COUNT);
  localparam int PRIO_W      = 6;
  localparam int WAIT_W      = 32;
  localparam int SLICE_W     = 8;
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd10;

  localparam logic [CFG_IDX_W-1:0] CFG_ROUND_ROBIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_TICKS = 1'd1;

  typedef enum logic [1:0] {
    M_FREE  = 2'd0,
    M_READY = 2'd1,
    M_RUN   = 2'd2,
    M_PEND  = 2'd3
  } mode_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_REGISTER   = 3'd0,
    CMD_UNREGISTER = 3'd1,
    CMD_READY      = 3'd2,
    CMD_SUSPEND    = 3'd3,
    CMD_TICK       = 3'd4,
    CMD_SCHEDULE   = 3'd5,
    CMD_START      = 3'd6,
    CMD_UNKNOWN    = 3'd7
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_TAKEN   = 2'd2,
    ST_NONE    = 2'd3
  } status_t;

  // Operations broadcast from the sequencer to every task cell.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_REG,
    OP_READY_PEND,
    OP_UNREG_PEND,
    OP_UNREG_FIFO,
    OP_SUSPEND,
    OP_WAKE,
    OP_SLICE_DEC,
    OP_ROTATE,
    OP_SWITCH
  } cell_op_t;

  typedef struct packed {
    cell_op_t             op;
    logic [TASK_W-1:0]    tgt;
    logic [TASK_W-1:0]    tgt2;
    logic [LEVEL_W-1:0]   level;
    logic [TASK_W-1:0]    rank_cmp;
    logic [TASK_W-1:0]    rank_new;
    logic [TASK_W-1:0]    stamp;
    logic [CNT_W-1:0]     k;
    logic [WAIT_W-1:0]    wake;
    logic [SLICE_W-1:0]   slice;
  } bcast_t;

  typedef struct packed {
    mode_t                mode;
    logic [LEVEL_W-1:0]   level;
    logic [TASK_W-1:0]    rank;
    logic [TASK_W-1:0]    stamp;
    logic [SLICE_W-1:0]   slice;
    logic                 in_fifo;
    logic                 at_level;
    logic                 after;
    logic                 wake_hit;
  } cell_info_t;

  typedef struct packed {
    logic                 found;
    logic [LEVEL_W-1:0]   level;
    logic [TASK_W-1:0]    rank;
    logic [TASK_W-1:0]    id;
  } token_t;

endpackage

// ===== hw/rtl/priority_task_scheduler_unit.sv =====
// Priority task scheduler for a small real-time kernel.
// Requests arrive on the in_ channel (valid/ready): a command, a task id, a
// priority for register and a timeout for suspend. Every request produces
// exactly one response on the out_ channel (valid/ready) carrying the status,
// the running task, a switch flag, the mask of tasks woken by timeout and the
// pending-reschedule flag. Configuration (round robin enable, timeslice) is
// written through cfg_we/cfg_index/cfg_wdata with no handshake.
// The state lives in a row of sixteen task cells. Register, unregister,
// ready, suspend and unknown commands go from acceptance through the execute
// state to the response. A tick walks the sixteen suspension ranks in one pass
// to wake expired tasks, then ages or rotates the running task's timeslice.
// Schedule and start, when they search, wait for the search token that moves
// through the sixteen cells one cell per cycle; otherwise they go straight
// from execute to the response. One request is handled at a time.
// A new request is accepted while the previous response is still waiting on
// the output; when the receiver stalls, the next response is held back until
// the output register frees. The synchronous reset leaves all tasks
// unregistered, the scheduler unstarted, round robin on and a timeslice of 10.
module priority_task_scheduler_unit
  import pts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CMD_W-1:0]      in_command,
  input  logic [TASK_W-1:0]     in_task_id,
  input  logic [PRIO_W-1:0]     in_priority_req,
  input  logic [WAIT_W-1:0]     in_wait_ticks,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   out_status,
  output logic [TASK_W-1:0]     out_running_task,
  output logic                  out_switch_now,
  output logic [TASK_COUNT-1:0] out_woken_mask,
  output logic                  out_resched_pending,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_WAKE, S_ROT, S_SCAN, S_PICK, S_DONE
  } state_t;

  state_t                state_r, state_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic [TASK_W-1:0]     tid_r, tid_nxt;
  logic [PRIO_W-1:0]     pr_r, pr_nxt;
  logic [WAIT_W-1:0]     wt_r, wt_nxt;
  logic [WAIT_W-1:0]     tc_r, tc_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [TASK_W-1:0]     cur_r, cur_nxt;
  logic                  started_r, started_nxt;
  logic                  resched_r, resched_nxt;
  logic                  rr_r, rr_nxt;
  logic [SLICE_W-1:0]    slicecfg_r, slicecfg_nxt;
  logic [TASK_W-1:0]     step_r, step_nxt;
  logic [CNT_W-1:0]      k_r, k_nxt;
  logic [TASK_COUNT-1:0] woken_r, woken_nxt;
  status_t               status_r, status_nxt;
  logic                  sw_r, sw_nxt;
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [TASK_W-1:0]     out_task_r, out_task_nxt;
  logic                  out_sw_r, out_sw_nxt;
  logic [TASK_COUNT-1:0] out_woken_r, out_woken_nxt;
  logic                  out_resched_r, out_resched_nxt;

  bcast_t                bc;
  cell_info_t            infos [TASK_COUNT];
  token_t                tok_chain [TASK_COUNT+1];
  logic [TASK_COUNT-1:0] at_level_vec, after_vec, hit_vec, fifo_vec, run_vec;
  cell_info_t            info_t, info_c;
  token_t                tok_last;

  assign tok_chain[0] = '0;

  for (genvar i = 0; i < TASK_COUNT; i++) begin : g_cell
    pts_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cell_id (TASK_W'(i)),
      .bc      (bc),
      .tok_in  (tok_chain[i]),
      .tok_out (tok_chain[i+1]),
      .info    (infos[i])
    );
    assign at_level_vec[i] = infos[i].at_level;
    assign after_vec[i]    = infos[i].after;
    assign hit_vec[i]      = infos[i].wake_hit;
    assign fifo_vec[i]     = infos[i].in_fifo;
    assign run_vec[i]      = (infos[i].mode == M_RUN);
  end

  assign info_t   = infos[tid_r];
  assign info_c   = infos[cur_r];
  assign tok_last = tok_chain[TASK_COUNT];

  assign in_ready            = (state_r == S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_running_task    = out_task_r;
  assign out_switch_now      = out_sw_r;
  assign out_woken_mask      = out_woken_r;
  assign out_resched_pending = out_resched_r;

  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    tid_nxt         = tid_r;
    pr_nxt          = pr_r;
    wt_nxt          = wt_r;
    tc_nxt          = tc_r;
    cnt_nxt         = cnt_r;
    cur_nxt         = cur_r;
    started_nxt     = started_r;
    resched_nxt     = resched_r;
    rr_nxt          = rr_r;
    slicecfg_nxt    = slicecfg_r;
    step_nxt        = step_r;
    k_nxt           = k_r;
    woken_nxt       = woken_r;
    status_nxt      = status_r;
    sw_nxt          = sw_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_status_nxt  = out_status_r;
    out_task_nxt    = out_task_r;
    out_sw_nxt      = out_sw_r;
    out_woken_nxt   = out_woken_r;
    out_resched_nxt = out_resched_r;

    bc          = '0;
    bc.op       = OP_NONE;
    bc.tgt      = tid_r;
    bc.tgt2     = cur_r;
    bc.level    = pr_r[LEVEL_W-1:0];
    bc.rank_cmp = info_t.rank;
    bc.rank_new = cnt_r[TASK_W-1:0];
    bc.stamp    = info_t.stamp;
    bc.k        = k_r;
    bc.wake     = tc_r + wt_r;
    bc.slice    = slicecfg_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_ROUND_ROBIN: rr_nxt       = cfg_wdata[0];
        CFG_SLICE_TICKS: slicecfg_nxt = cfg_wdata[SLICE_W-1:0];
        default: begin
        end
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt    = cmd_t'(in_command);
          tid_nxt    = in_task_id;
          pr_nxt     = in_priority_req;
          wt_nxt     = in_wait_ticks;
          woken_nxt  = '0;
          sw_nxt     = 1'b0;
          status_nxt = ST_OK;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_DONE;
        case (cmd_r)
          CMD_REGISTER: begin
            if (info_t.mode != M_FREE || pr_r >= PRIO_W'(LEVEL_COUNT)) begin
              status_nxt = ST_INVALID;
            end else if (!rr_r && (|at_level_vec)) begin
              status_nxt = ST_TAKEN;
            end else begin
              bc.op       = OP_REG;
              cnt_nxt     = cnt_r + 1'b1;
              resched_nxt = 1'b1;
            end
          end
          CMD_UNREGISTER: begin
            if (info_t.mode == M_FREE) begin
              status_nxt = ST_INVALID;
            end else if (info_t.mode == M_PEND) begin
              bc.op = OP_UNREG_PEND;
            end else begin
              bc.op   = OP_UNREG_FIFO;
              cnt_nxt = cnt_r - 1'b1;
            end
          end
          CMD_READY: begin
            if (info_t.mode == M_FREE) begin
              status_nxt = ST_INVALID;
            end else if (info_t.mode == M_PEND) begin
              bc.op       = OP_READY_PEND;
              cnt_nxt     = cnt_r + 1'b1;
              resched_nxt = 1'b1;
            end
          end
          CMD_SUSPEND: begin
            if (info_t.mode != M_READY && info_t.mode != M_RUN) begin
              status_nxt = ST_INVALID;
            end else begin
              bc.op       = OP_SUSPEND;
              cnt_nxt     = cnt_r - 1'b1;
              resched_nxt = 1'b1;
            end
          end
          CMD_TICK: begin
            tc_nxt    = tc_r + 1'b1;
            step_nxt  = '0;
            k_nxt     = '0;
            state_nxt = S_WAKE;
          end
          CMD_SCHEDULE: begin
            if (resched_r && started_r) begin
              step_nxt  = '0;
              state_nxt = S_SCAN;
            end
          end
          CMD_START: begin
            if (started_r) begin
              status_nxt = ST_INVALID;
            end else begin
              step_nxt  = '0;
              state_nxt = S_SCAN;
            end
          end
          default: status_nxt = ST_INVALID;
        endcase
      end
      S_WAKE: begin
        // One suspension rank per cycle, most recent first.
        bc.op    = OP_WAKE;
        bc.stamp = step_r;
        bc.wake  = tc_r;
        if (|hit_vec) begin
          woken_nxt   = woken_r | hit_vec;
          cnt_nxt     = cnt_r + 1'b1;
          k_nxt       = k_r + 1'b1;
          resched_nxt = 1'b1;
        end
        step_nxt = step_r + 1'b1;
        if (step_r == TASK_W'(TASK_COUNT - 1)) begin
          state_nxt = S_ROT;
        end
      end
      S_ROT: begin
        bc.tgt      = cur_r;
        bc.level    = info_c.level;
        bc.rank_cmp = info_c.rank;
        bc.rank_new = TASK_W'(cnt_r - 1'b1);
        if (rr_r && started_r && info_c.in_fifo && (|after_vec)) begin
          if (info_c.slice == SLICE_W'(1)) begin
            bc.op       = OP_ROTATE;
            resched_nxt = 1'b1;
          end else begin
            bc.op = OP_SLICE_DEC;
          end
        end
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        // Let the search token cross the whole row of cells.
        step_nxt = step_r + 1'b1;
        if (step_r == TASK_W'(TASK_COUNT - 1)) begin
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        bc.tgt  = tok_last.id;
        bc.tgt2 = cur_r;
        if (!tok_last.found) begin
          status_nxt = ST_NONE;
        end else if (cmd_r == CMD_START || tok_last.id != cur_r) begin
          bc.op       = OP_SWITCH;
          cur_nxt     = tok_last.id;
          resched_nxt = 1'b0;
          started_nxt = 1'b1;
          sw_nxt      = 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_status_nxt  = status_r;
          out_task_nxt    = cur_r;
          out_sw_nxt      = sw_r;
          out_woken_nxt   = woken_r;
          out_resched_nxt = resched_r;
          state_nxt       = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tc_r        <= '0;
      cnt_r       <= '0;
      cur_r       <= '0;
      started_r   <= 1'b0;
      resched_r   <= 1'b0;
      rr_r        <= 1'b1;
      slicecfg_r  <= SLICE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tc_r        <= tc_nxt;
      cnt_r       <= cnt_nxt;
      cur_r       <= cur_nxt;
      started_r   <= started_nxt;
      resched_r   <= resched_nxt;
      rr_r        <= rr_nxt;
      slicecfg_r  <= slicecfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r         <= cmd_nxt;
    tid_r         <= tid_nxt;
    pr_r          <= pr_nxt;
    wt_r          <= wt_nxt;
    step_r        <= step_nxt;
    k_r           <= k_nxt;
    woken_r       <= woken_nxt;
    status_r      <= status_nxt;
    sw_r          <= sw_nxt;
    out_status_r  <= out_status_nxt;
    out_task_r    <= out_task_nxt;
    out_sw_r      <= out_sw_nxt;
    out_woken_r   <= out_woken_nxt;
    out_resched_r <= out_resched_nxt;
  end

  // Once started, the scheduler never returns to the unstarted state.
  a_started_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    started_r |=> started_r) else $error("started flag dropped");

  // At most one task is ever marked running.
  a_one_running: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(run_vec) <= 1) else $error("several running tasks");

  // While idle, the FIFO fill count matches the cells that sit in a ready FIFO.
  a_fifo_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> cnt_r == CNT_W'($countones(fifo_vec)))
    else $error("fifo count out of step with cells");

  // A switch is only reported with a successful status.
  a_switch_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_sw_r |-> out_status_r == ST_OK)
    else $error("switch reported with error status");

endmodule

// ===== hw/rtl/pts_cell.sv =====
module pts_cell
  import pts_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [TASK_W-1:0] cell_id,
  input  bcast_t            bc,
  input  token_t            tok_in,
  output token_t            tok_out,
  output cell_info_t        info
);

  mode_t               mode_r, mode_nxt;
  logic [LEVEL_W-1:0]  level_r, level_nxt;
  logic [TASK_W-1:0]   rank_r, rank_nxt;
  logic [TASK_W-1:0]   stamp_r, stamp_nxt;
  logic [WAIT_W-1:0]   wake_r, wake_nxt;
  logic [SLICE_W-1:0]  slice_r, slice_nxt;
  token_t              tok_r, tok_nxt;
  logic                is_me, in_fifo, pend, better;

  assign is_me   = (cell_id == bc.tgt);
  assign in_fifo = (mode_r == M_READY) || (mode_r == M_RUN);
  assign pend    = (mode_r == M_PEND);

  assign info.mode     = mode_r;
  assign info.level    = level_r;
  assign info.rank     = rank_r;
  assign info.stamp    = stamp_r;
  assign info.slice    = slice_r;
  assign info.in_fifo  = in_fifo;
  assign info.at_level = in_fifo && (level_r == bc.level);
  assign info.after    = in_fifo && (level_r == bc.level) && (rank_r > bc.rank_cmp);
  assign info.wake_hit = pend && (stamp_r == bc.stamp) && (wake_r == bc.wake);

  // The search token picks the highest level, and inside a level the oldest entry.
  assign better = in_fifo && (!tok_in.found || (level_r > tok_in.level) ||
                  ((level_r == tok_in.level) && (rank_r < tok_in.rank)));
  assign tok_out = tok_r;

  always_comb begin
    mode_nxt  = mode_r;
    level_nxt = level_r;
    rank_nxt  = rank_r;
    stamp_nxt = stamp_r;
    wake_nxt  = wake_r;
    slice_nxt = slice_r;
    tok_nxt   = tok_in;
    if (better) begin
      tok_nxt.found = 1'b1;
      tok_nxt.level = level_r;
      tok_nxt.rank  = rank_r;
      tok_nxt.id    = cell_id;
    end
    case (bc.op)
      OP_REG: begin
        if (is_me) begin
          mode_nxt  = M_READY;
          level_nxt = bc.level;
          rank_nxt  = bc.rank_new;
          slice_nxt = bc.slice;
        end
      end
      OP_READY_PEND: begin
        if (is_me) begin
          mode_nxt  = M_READY;
          rank_nxt  = bc.rank_new;
          slice_nxt = bc.slice;
        end else if (pend && stamp_r > bc.stamp) begin
          stamp_nxt = stamp_r - 1'b1;
        end
      end
      OP_UNREG_PEND: begin
        if (is_me) begin
          mode_nxt = M_FREE;
        end else if (pend && stamp_r > bc.stamp) begin
          stamp_nxt = stamp_r - 1'b1;
        end
      end
      OP_UNREG_FIFO: begin
        if (is_me) begin
          mode_nxt = M_FREE;
        end else if (in_fifo && rank_r > bc.rank_cmp) begin
          rank_nxt = rank_r - 1'b1;
        end
      end
      OP_SUSPEND: begin
        if (is_me) begin
          mode_nxt  = M_PEND;
          stamp_nxt = '0;
          wake_nxt  = bc.wake;
        end else if (in_fifo && rank_r > bc.rank_cmp) begin
          rank_nxt = rank_r - 1'b1;
        end else if (pend) begin
          stamp_nxt = stamp_r + 1'b1;
        end
      end
      OP_WAKE: begin
        if (info.wake_hit) begin
          mode_nxt  = M_READY;
          rank_nxt  = bc.rank_new;
          slice_nxt = bc.slice;
        end else if (pend && stamp_r == bc.stamp) begin
          stamp_nxt = stamp_r - bc.k[TASK_W-1:0];
        end
      end
      OP_SLICE_DEC: begin
        if (is_me) begin
          slice_nxt = slice_r - 1'b1;
        end
      end
      OP_ROTATE: begin
        if (is_me) begin
          mode_nxt  = M_READY;
          rank_nxt  = bc.rank_new;
          slice_nxt = bc.slice;
        end else if (in_fifo && rank_r > bc.rank_cmp) begin
          rank_nxt = rank_r - 1'b1;
        end
      end
      OP_SWITCH: begin
        if (is_me) begin
          mode_nxt = M_RUN;
        end else if (cell_id == bc.tgt2 && mode_r == M_RUN) begin
          mode_nxt = M_READY;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_FREE;
      level_r <= '0;
    end else begin
      mode_r  <= mode_nxt;
      level_r <= level_nxt;
    end
    rank_r  <= rank_nxt;
    stamp_r <= stamp_nxt;
    wake_r  <= wake_nxt;
    slice_r <= slice_nxt;
    tok_r   <= tok_nxt;
  end

endmodule
